@@ design/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared constants, codes and types of the go-back-N sender.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

	// Widths of counters, registers and the resend total.
	localparam int CNT_W      = 16;
	localparam int SEQ_BITS   = 16;
	localparam int WIN_W      = 7;
	localparam int TOTAL_W    = 24;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int MAX_WINDOW = 64;

	// Register reset values.
	localparam logic [WIN_W-1:0] WINDOW_RST  = WIN_W'(4);
	localparam logic [CNT_W-1:0] TIMEOUT_RST = CNT_W'(1500);
	localparam logic [CNT_W-1:0] MSGCNT_RST  = CNT_W'(1000);

	localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Stream widths: tdata padded to whole bytes.
	localparam int IN_DATA_W  = 16;
	localparam int IN_USER_W  = 2;
	localparam int OUT_BITS   = 1 + SEQ_BITS + 1 + 1 + 1 + TOTAL_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Event kinds.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_ACK   = 2'd1,
		OP_START = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MSGCNT  = 2'd2;

	// One result of an event.
	typedef struct packed {
		logic                done_res;
		logic [TOTAL_W-1:0]  resent_total;
		logic                timed_out;
		logic                ack_taken;
		logic                is_resend;
		logic [SEQ_BITS-1:0] send_seq;
		logic                send_valid;
	} result_t;

endpackage

`default_nettype wire

@@ design/gbn_core.sv @@
// ----------------------------------------------------------------------------
// gbn_core
// Configuration registers, window state and the combinational event update.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gbn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gbn_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          ev_valid,
	input  wire logic [1:0]                    ev_op,
	input  wire logic [gbn_pkg::CNT_W-1:0]     ev_ack_seq,
	output gbn_pkg::result_t                   ev_result
);
	import gbn_pkg::*;

	logic [WIN_W-1:0]   window_size_q;
	logic [CNT_W-1:0]   timeout_ticks_q;
	logic [CNT_W-1:0]   message_count_q;

	logic [CNT_W-1:0]   window_base_q, next_seq_q, highest_sent_q, wait_timer_q;
	logic [TOTAL_W-1:0] resend_count_q;
	logic               running_q;

	logic [CNT_W-1:0]   base_d, seq_d, high_d, timer_d;
	logic [TOTAL_W-1:0] resend_d;
	logic               running_d;

	logic [CNT_W-1:0]   outs0, outs1, seq1, seq2, timer1;
	logic [WIN_W-1:0]   eff_window;
	logic [TOTAL_W:0]   resend_sum;
	logic               send_ok, fire, ack_hit;
	op_t                op;

	assign op = op_t'(ev_op);

	// Window register clamped to 1..MAX_WINDOW.
	always_comb begin
		if (window_size_q == '0)
			eff_window = WIN_W'(1);
		else if (window_size_q > WIN_W'(MAX_WINDOW))
			eff_window = WIN_W'(MAX_WINDOW);
		else
			eff_window = window_size_q;
	end

	// Outstanding count before and after a possible rewind.
	assign outs0 = (next_seq_q > window_base_q) ? (next_seq_q - window_base_q) : '0;
	assign timer1 = (wait_timer_q < CNT_MAX) ? (wait_timer_q + CNT_W'(1)) : wait_timer_q;
	assign fire = (outs0 != '0) && (timer1 > timeout_ticks_q);
	assign seq1 = fire ? window_base_q : next_seq_q;
	assign outs1 = (seq1 > window_base_q) ? (seq1 - window_base_q) : '0;
	assign seq2 = seq1 + CNT_W'(1);
	assign send_ok = (outs1 < CNT_W'(eff_window)) && (seq1 < message_count_q);
	assign resend_sum = {1'b0, resend_count_q} + (TOTAL_W + 1)'(outs0);
	assign ack_hit = (outs0 != '0) &&
		(ev_ack_seq[SEQ_BITS-1:0] == window_base_q[SEQ_BITS-1:0]);

	// Next state and result of the event.
	always_comb begin
		base_d    = window_base_q;
		seq_d     = next_seq_q;
		high_d    = highest_sent_q;
		timer_d   = wait_timer_q;
		resend_d  = resend_count_q;
		running_d = running_q;
		ev_result = '0;
		unique case (op)
			OP_START: begin
				base_d    = '0;
				seq_d     = '0;
				high_d    = '0;
				timer_d   = '0;
				resend_d  = '0;
				running_d = 1'b1;
			end
			OP_ACK: begin
				if (running_q && ack_hit) begin
					base_d = window_base_q + CNT_W'(1);
					timer_d = '0;
					ev_result.ack_taken = 1'b1;
				end
			end
			OP_TICK: begin
				if (running_q) begin
					if (outs0 != '0)
						timer_d = timer1;
					if (fire) begin
						resend_d = resend_sum[TOTAL_W] ? TOTAL_MAX : resend_sum[TOTAL_W-1:0];
						seq_d = seq1;
						timer_d = '0;
						ev_result.timed_out = 1'b1;
					end
					if (send_ok) begin
						ev_result.send_valid = 1'b1;
						ev_result.send_seq   = seq1[SEQ_BITS-1:0];
						ev_result.is_resend  = seq1 < highest_sent_q;
						if (outs1 == '0)
							timer_d = '0;
						seq_d = seq2;
						if (seq2 > highest_sent_q)
							high_d = seq2;
					end
				end
			end
			default: begin
			end
		endcase
		ev_result.resent_total = resend_d;
		ev_result.done_res = running_d && (base_d >= message_count_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= WINDOW_RST;
			timeout_ticks_q <= TIMEOUT_RST;
			message_count_q <= MSGCNT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_WINDOW)
				window_size_q <= cfg_data[WIN_W-1:0];
			else if (cfg_index == REG_TIMEOUT)
				timeout_ticks_q <= cfg_data[CNT_W-1:0];
			else if (cfg_index == REG_MSGCNT)
				message_count_q <= cfg_data[CNT_W-1:0];
		end
	end

	// Window state, updated once per accepted event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_base_q  <= '0;
			next_seq_q     <= '0;
			highest_sent_q <= '0;
			wait_timer_q   <= '0;
			resend_count_q <= '0;
			running_q      <= 1'b0;
		end else if (ev_valid) begin
			window_base_q  <= base_d;
			next_seq_q     <= seq_d;
			highest_sent_q <= high_d;
			wait_timer_q   <= timer_d;
			resend_count_q <= resend_d;
			running_q      <= running_d;
		end
	end

endmodule

`default_nettype wire

@@ design/go_back_n_sender_top.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-back-N sliding-window sender: one result for every input event.
// ----------------------------------------------------------------------------
// Each event (tick, ack, start or none, selected by s_axis_tuser) is handled in the
// cycle it is accepted and gives exactly one result, which the output register holds
// from the next cycle on. One event per clock is sustained as long as the result
// side takes a transfer every cycle; the output register is the only stage.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect on the
// next event and are meant to be made while no event is in flight.
`default_nettype none

module go_back_n_sender_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gbn_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// ack_seq[15:0]
	input  wire logic [gbn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  wire logic [gbn_pkg::IN_USER_W-1:0]  s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// send_valid[0], send_seq[16:1], is_resend[17], ack_taken[18],
	// timed_out[19], resent_total[43:20], done_res[44], zero[47:45]
	output logic [gbn_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
	import gbn_pkg::*;

	logic    accept;
	result_t result;
	logic    out_valid_q;
	result_t out_data_q;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	gbn_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ev_valid   (accept),
		.ev_op      (s_axis_tuser),
		.ev_ack_seq (s_axis_tdata[CNT_W-1:0]),
		.ev_result  (result)
	);

	// Output register holds the result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_data_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_data_q);

endmodule

`default_nettype wire

@@ dv/gbn_checker.sv @@
// ----------------------------------------------------------------------------
// gbn_checker
// Watches the event and result streams of the go-back-N sender, predicts
// each result from its own copy of the sender state and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gbn_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           s_axis_tvalid,
	input  wire logic                           s_axis_tready,
	input  wire logic [gbn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  wire logic [gbn_pkg::IN_USER_W-1:0]  s_axis_tuser,
	input  wire logic                           m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	input  wire logic [gbn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output int                                  fail_count,
	output int                                  n_pending,
	output logic [gbn_pkg::CNT_W-1:0]           base_hint
);

	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	// Shadow copies of the registers and the sender state.
	logic [WIN_W-1:0]   window_reg;
	logic [CNT_W-1:0]   timeout_reg;
	logic [CNT_W-1:0]   msg_count_reg;
	logic [CNT_W-1:0]   base_seq;
	logic [CNT_W-1:0]   next_seq;
	logic [CNT_W-1:0]   top_sent;
	logic [CNT_W-1:0]   retry_timer;
	logic [TOTAL_W-1:0] resend_total;
	logic               xfer_running;

	result_t expected_results[$];
	int      mismatches = 0;

	assign fail_count = mismatches;

	// Messages sent but not yet acknowledged.
	function automatic logic [CNT_W-1:0] in_flight();
		return (next_seq > base_seq) ? next_seq - base_seq : '0;
	endfunction

	// Window register clamped to the legal range.
	function automatic logic [WIN_W-1:0] window_limit();
		if (window_reg == '0)
			return WIN_W'(1);
		if (window_reg > WIN_W'(MAX_WINDOW))
			return WIN_W'(MAX_WINDOW);
		return window_reg;
	endfunction

	// Applies one event to the shadow state and returns its result.
	function automatic result_t sender_result(op_t op, logic [CNT_W-1:0] ack);
		result_t            res;
		logic [CNT_W-1:0]   outs;
		logic [TOTAL_W-1:0] room;
		res = '0;
		case (op)
			OP_START: begin
				base_seq     = '0;
				next_seq     = '0;
				top_sent     = '0;
				retry_timer  = '0;
				resend_total = '0;
				xfer_running = 1'b1;
			end
			OP_ACK: begin
				if (xfer_running && in_flight() != '0 && ack == base_seq) begin
					base_seq      = base_seq + 1'b1;
					retry_timer   = '0;
					res.ack_taken = 1'b1;
				end
			end
			OP_TICK: begin
				if (xfer_running) begin
					outs = in_flight();
					// The timer only runs while something is unacknowledged.
					if (outs != '0) begin
						if (retry_timer != CNT_MAX)
							retry_timer = retry_timer + 1'b1;
						if (retry_timer > timeout_reg) begin
							room = TOTAL_MAX - resend_total;
							resend_total = (TOTAL_W'(outs) > room) ? TOTAL_MAX
								: resend_total + TOTAL_W'(outs);
							next_seq      = base_seq;
							retry_timer   = '0;
							res.timed_out = 1'b1;
						end
					end
					// Send the next message when the window has room.
					if (in_flight() < CNT_W'(window_limit()) && next_seq < msg_count_reg) begin
						res.send_valid = 1'b1;
						res.send_seq   = next_seq;
						res.is_resend  = next_seq < top_sent;
						if (in_flight() == '0)
							retry_timer = '0;
						next_seq = next_seq + 1'b1;
						if (next_seq > top_sent)
							top_sent = next_seq;
					end
				end
			end
			default: begin
			end
		endcase
		res.resent_total = resend_total;
		res.done_res     = xfer_running && base_seq >= msg_count_reg;
		return res;
	endfunction

	// Reports one field that differs from the prediction.
	function automatic void check_field(string name, logic [TOTAL_W-1:0] want,
		logic [TOTAL_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare result transfers, track register writes, predict event transfers.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			window_reg    = WINDOW_RST;
			timeout_reg   = TIMEOUT_RST;
			msg_count_reg = MSGCNT_RST;
			base_seq      = '0;
			next_seq      = '0;
			top_sent      = '0;
			retry_timer   = '0;
			resend_total  = '0;
			xfer_running  = 1'b0;
			expected_results.delete();
			n_pending <= 0;
			base_hint <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[OUT_BITS-1:0]);
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result transfer 0x%0h", $time, m_axis_tdata);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("send_valid", TOTAL_W'(want.send_valid),
						TOTAL_W'(got.send_valid));
					check_field("send_seq", TOTAL_W'(want.send_seq),
						TOTAL_W'(got.send_seq));
					check_field("is_resend", TOTAL_W'(want.is_resend),
						TOTAL_W'(got.is_resend));
					check_field("ack_taken", TOTAL_W'(want.ack_taken),
						TOTAL_W'(got.ack_taken));
					check_field("timed_out", TOTAL_W'(want.timed_out),
						TOTAL_W'(got.timed_out));
					check_field("resent_total", want.resent_total, got.resent_total);
					check_field("done_res", TOTAL_W'(want.done_res),
						TOTAL_W'(got.done_res));
					check_field("padding", '0,
						TOTAL_W'(m_axis_tdata[OUT_DATA_W-1:OUT_BITS]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW:  window_reg    = cfg_data[WIN_W-1:0];
					REG_TIMEOUT: timeout_reg   = cfg_data[CNT_W-1:0];
					REG_MSGCNT:  msg_count_reg = cfg_data[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(sender_result(op_t'(s_axis_tuser), s_axis_tdata));
			n_pending <= expected_results.size();
			base_hint <= base_seq;
		end
	end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench top of the go-back-N sender: drives directed and random events
// with random gaps and result back-pressure, and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 500;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	int               fail_count;
	int               n_pending;
	logic [CNT_W-1:0] base_hint;
	logic             no_stall = 1'b0;
	int               ready_hold = 0;

	go_back_n_sender_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	gbn_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.n_pending     (n_pending),
		.base_hint     (base_hint)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side back-pressure.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= 0;
		end else if (no_stall) begin
			m_axis_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if (m_axis_tready && $urandom_range(0, 2) == 0) begin
			m_axis_tready <= 1'b0;
			ready_hold    <= pick_gap();
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// One event transfer, after a random gap unless idling is off.
	task automatic send_event(input op_t op, input logic [IN_DATA_W-1:0] ack);
		int gap;
		gap = no_stall ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= ack;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Stop sending and wait until every expected result has arrived.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Register write, made only while the sender is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Ack value: mostly the current base or just past it, sometimes just below it or anything.
	function automatic logic [IN_DATA_W-1:0] pick_ack(input bit noisy);
		int r;
		r = $urandom_range(0, 99);
		if (noisy || r < 10)
			return IN_DATA_W'($urandom);
		if (r < 75)
			return base_hint;
		if (r < 90)
			return base_hint + 1'b1;
		return base_hint - IN_DATA_W'($urandom_range(1, 3));
	endfunction

	// Register values for one phase, the extremes often among them.
	function automatic logic [CFG_W-1:0] pick_window();
		logic [WIN_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = WIN_W'(0);
			1: w = WIN_W'(1);
			2: w = WIN_W'(2);
			3: w = WIN_W'(3);
			4: w = WIN_W'(4);
			5: w = WIN_W'(8);
			6: w = WIN_W'(MAX_WINDOW);
			7: w = WIN_W'(MAX_WINDOW + 1);
			8: w = {WIN_W{1'b1}};
			default: w = WIN_W'($urandom_range(1, 16));
		endcase
		return {(CFG_W - WIN_W)'($urandom), w};
	endfunction

	function automatic logic [CFG_W-1:0] pick_timeout();
		case ($urandom_range(0, 7))
			0: return CFG_W'(0);
			1: return CFG_W'(1);
			2: return CFG_W'(2);
			3: return CFG_W'(5);
			4: return CFG_W'(20);
			5: return CNT_MAX;
			6: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(1, 40));
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_count();
		case ($urandom_range(0, 6))
			0: return CFG_W'(1);
			1: return CFG_W'(2);
			2: return CFG_W'(3);
			3: return CNT_MAX;
			4: return CFG_W'($urandom);
			default: return CFG_W'($urandom_range(1, 40));
		endcase
	endfunction

	// Watchdog.
	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		int   random_sent;
		int   n_events;
		int   r;
		bit   noisy;
		op_t  op;

		random_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Not running yet: ticks, acks and unknown events change nothing.
		send_event(OP_TICK, 16'h0000);
		send_event(OP_ACK, 16'h0000);
		send_event(OP_NONE, 16'hFFFF);
		// Fill the default window of four, then one tick with the window full.
		send_event(OP_START, 16'h0000);
		repeat (5) send_event(OP_TICK, 16'h0000);
		// Ack other than the base is ignored; the base ack slides the window.
		send_event(OP_ACK, 16'h0005);
		send_event(OP_ACK, 16'h0000);
		send_event(OP_TICK, 16'h0000);
		send_event(OP_ACK, 16'hFFFF);
		// Start again while a transfer is in progress.
		send_event(OP_START, 16'hFFFF);
		send_event(OP_NONE, 16'h0000);

		// Window zero acts as one, timeout zero fires on the first waiting tick.
		write_reg(REG_WINDOW, 16'h0000);
		write_reg(REG_TIMEOUT, 16'h0000);
		write_reg(REG_MSGCNT, 16'h0002);
		send_event(OP_START, 16'h0000);
		send_event(OP_TICK, 16'h0000);
		send_event(OP_TICK, 16'h0000);
		send_event(OP_ACK, 16'h0000);
		send_event(OP_TICK, 16'h0000);
		send_event(OP_ACK, 16'h0001);
		send_event(OP_TICK, 16'h0000);

		// Window above the maximum, timeout that never fires, largest count.
		write_reg(REG_WINDOW, 16'hFF7F);
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_MSGCNT, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_event(OP_START, 16'h0000);
		repeat (3) send_event(OP_TICK, 16'h0000);
		send_event(OP_ACK, 16'h0000);

		// Random phases, each with its own register setting.
		while (random_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_WINDOW, pick_window());
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_TIMEOUT, pick_timeout());
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_MSGCNT, pick_count());
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, CFG_W'($urandom));
			no_stall <= ($urandom_range(0, 3) == 0);
			noisy = ($urandom_range(0, 4) == 0);
			n_events = $urandom_range(20, 60);
			// Most phases begin a fresh transfer; the rest carry on under the
			// new setting, which may put the count below the progress so far.
			if ($urandom_range(0, 9) < 8) begin
				send_event(OP_START, IN_DATA_W'($urandom));
				random_sent++;
			end
			repeat (n_events) begin
				if (noisy) begin
					op = op_t'($urandom_range(0, 3));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 58)
						op = OP_TICK;
					else if (r < 94)
						op = OP_ACK;
					else if (r < 97)
						op = OP_START;
					else
						op = OP_NONE;
				end
				send_event(op, (op == OP_ACK) ? pick_ack(noisy) : IN_DATA_W'($urandom));
				if (op != OP_NONE)
					random_sent++;
			end
		end

		drain();
		repeat (5) @(posedge clk);
		if (fail_count == 0 && n_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
